### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for the concurrent checks in the allpass RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/svfap_pkg.sv
// ----------------------------------------------------------------------------
// svfap_pkg
// Shared widths, register indexes and interface types of the allpass block.
// ----------------------------------------------------------------------------
`default_nettype none

package svfap_pkg;

    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 24;
    localparam int STATE_W    = 32;
    localparam int G_W        = 24;
    localparam int H_W        = 25;
    localparam int CFG_DATA_W = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int Q24_FRAC   = 24;
    localparam int G_FRAC     = 16;

    localparam int MAX_CHANNELS         = 2 ** CH_W;
    localparam int DEFAULT_NUM_CHANNELS = 8;

    // sqrt(2) in unsigned Q1.24.
    localparam logic [H_W-1:0] SQRT2_Q24 = 25'd23726566;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_G = 2'd0,
        REG_COEF_H = 2'd1,
        REG_BYPASS = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic                       req_type;
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] sample_in;
    } item_t;

    typedef struct packed {
        logic [G_W-1:0] coef_g;
        logic [H_W-1:0] coef_h;
        logic           bypass;
    } cfg_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_en;
    } mem_cmd_t;

    typedef struct packed {
        logic [CH_W-1:0]            channel;
        logic signed [SAMPLE_W-1:0] value;
    } result_t;

endpackage

`default_nettype wire

### hdl/svfap_mem.sv
// ----------------------------------------------------------------------------
// svfap_mem
// Per-channel integrator state memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module svfap_mem #(
    parameter int DEPTH = svfap_pkg::DEFAULT_NUM_CHANNELS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  svfap_pkg::mem_cmd_t               cmd,
    input  logic [AW-1:0]                     addr,
    input  logic [2*svfap_pkg::STATE_W-1:0]   wdata,
    output logic [2*svfap_pkg::STATE_W-1:0]   rdata
);
    import svfap_pkg::*;

    localparam int WORD_W = 2 * STATE_W;

    logic [WORD_W-1:0] mem_reg [DEPTH];
    logic [WORD_W-1:0] rdata_reg;
    logic              rd_valid_reg;
    logic [DEPTH-1:0]  valid_reg;
    logic [DEPTH-1:0]  valid_next;

    // An entry that was never written since reset or was cleared reads as zero.
    always_comb begin
        valid_next = valid_reg;
        if (cmd.wr_en) begin
            valid_next[addr] = 1'b1;
        end
        if (cmd.clr_en) begin
            valid_next[addr] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (cmd.rd_en) begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem_reg[addr] <= wdata;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem_reg[addr];
        end
    end

    assign rdata = rd_valid_reg ? rdata_reg : '0;

    `ASSERT_IMPLIES(a_wr_clr_exclusive, aclk, aresetn, cmd.wr_en, !cmd.clr_en, "write and clear in one cycle")

endmodule

`default_nettype wire

### hdl/svfap_core.sv
// ----------------------------------------------------------------------------
// svfap_core
// Sequencer and shared multiply/add datapath for one filter step per item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module svfap_core #(
    parameter int NUM_CHANNELS = svfap_pkg::DEFAULT_NUM_CHANNELS,
    parameter int AW = (((NUM_CHANNELS < svfap_pkg::MAX_CHANNELS) ? NUM_CHANNELS
                         : svfap_pkg::MAX_CHANNELS) > 1)
                       ? $clog2((NUM_CHANNELS < svfap_pkg::MAX_CHANNELS) ? NUM_CHANNELS
                                : svfap_pkg::MAX_CHANNELS)
                       : 1
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              start,
    input  svfap_pkg::item_t                  item,
    input  svfap_pkg::cfg_t                   cfg,
    output logic                              idle,
    output svfap_pkg::mem_cmd_t               mem_cmd,
    output logic [AW-1:0]                     mem_addr,
    output logic [2*svfap_pkg::STATE_W-1:0]   mem_wdata,
    input  logic [2*svfap_pkg::STATE_W-1:0]   mem_rdata,
    output logic                              res_valid,
    output svfap_pkg::result_t                res,
    input  logic                              res_taken
);
    import svfap_pkg::*;

    localparam int MUL_B_W = H_W + 1;
    localparam int PROD_W  = STATE_W + MUL_B_W;
    localparam int ACC_W   = PROD_W - G_FRAC + 2;

    localparam logic signed [PROD_W-1:0] RND_Q24 =
        {{(PROD_W-1){1'b0}}, 1'b1} << (Q24_FRAC - 1);
    localparam logic signed [PROD_W-1:0] RND_G =
        {{(PROD_W-1){1'b0}}, 1'b1} << (G_FRAC - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_STEP1,
        ST_STEP2,
        ST_STEP3,
        ST_STEP4,
        ST_STEP5,
        ST_STEP6,
        ST_STEP7,
        ST_STEP8,
        ST_STEP9,
        ST_STEP10,
        ST_STEP11,
        ST_STEP12,
        ST_FINISH
    } state_t;

    function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-STATE_W:0] top;
        top = v[ACC_W-1:STATE_W-1];
        if ((&top) || !(|top)) begin
            return v[STATE_W-1:0];
        end
        return v[ACC_W-1] ? {1'b1, {(STATE_W-1){1'b0}}} : {1'b0, {(STATE_W-1){1'b1}}};
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-SAMPLE_W:0] top;
        top = v[ACC_W-1:SAMPLE_W-1];
        if ((&top) || !(|top)) begin
            return v[SAMPLE_W-1:0];
        end
        return v[ACC_W-1] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    state_t                     state_reg;
    state_t                     state_next;
    logic                       req_reg;
    logic [CH_W-1:0]            ch_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic signed [SAMPLE_W-1:0] y_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [STATE_W-1:0]  t_reg;
    logic signed [STATE_W-1:0]  yh_reg;
    logic signed [STATE_W-1:0]  yb_reg;
    logic signed [STATE_W-1:0]  yl_reg;
    logic signed [STATE_W-1:0]  s1n_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [PROD_W-1:0]   prod_next;

    logic                       in_range;
    logic signed [STATE_W-1:0]  s1;
    logic signed [STATE_W-1:0]  s2;
    logic                       mul_en;
    logic signed [STATE_W-1:0]  mul_a;
    logic [H_W-1:0]             mul_b;
    logic signed [PROD_W-1:0]   rnd;
    logic signed [ACC_W-1:0]    p24;
    logic signed [ACC_W-1:0]    pg;
    logic signed [ACC_W-1:0]    add_a;
    logic signed [ACC_W-1:0]    add_b;
    logic                       add_sub;
    logic signed [ACC_W-1:0]    sum;
    logic signed [STATE_W-1:0]  sum_sat32;
    logic signed [SAMPLE_W-1:0] sum_sat24;

    assign in_range = int'(item.channel) < NUM_CHANNELS;

    // The read data stays put from the start of an item to its end, since
    // the next read is only issued when the next item is taken.
    assign s1 = $signed(mem_rdata[2*STATE_W-1:STATE_W]);
    assign s2 = $signed(mem_rdata[STATE_W-1:0]);

    assign mem_cmd.rd_en  = start && in_range && !cfg.bypass;
    assign mem_cmd.clr_en = start && in_range && cfg.bypass;
    assign mem_cmd.wr_en  = (state_reg == ST_STEP10);
    assign mem_addr       = (state_reg == ST_IDLE) ? AW'(item.channel) : AW'(ch_reg);
    assign mem_wdata      = {s1n_reg, sum_sat32};

    // Multiplier operand schedule. The rounding half LSB rides in the product.
    always_comb begin
        mul_en = 1'b1;
        mul_a  = s1;
        mul_b  = SQRT2_Q24;
        rnd    = RND_Q24;
        case (state_reg)
            ST_STEP1: begin
                mul_a = s1;
                mul_b = SQRT2_Q24;
                rnd   = RND_Q24;
            end
            ST_STEP2: begin
                mul_a = s1;
                mul_b = {1'b0, cfg.coef_g};
                rnd   = RND_G;
            end
            ST_STEP4: begin
                mul_a = t_reg;
                mul_b = cfg.coef_h;
                rnd   = RND_Q24;
            end
            ST_STEP6: begin
                mul_a = yh_reg;
                mul_b = {1'b0, cfg.coef_g};
                rnd   = RND_G;
            end
            ST_STEP8: begin
                mul_a = yb_reg;
                mul_b = {1'b0, cfg.coef_g};
                rnd   = RND_G;
            end
            ST_STEP10: begin
                mul_a = yb_reg;
                mul_b = SQRT2_Q24;
                rnd   = RND_Q24;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod_next = mul_a * $signed({1'b0, mul_b}) + rnd;
    assign p24       = ACC_W'(prod_reg >>> Q24_FRAC);
    assign pg        = ACC_W'(prod_reg >>> G_FRAC);

    // Adder operand schedule, one add or subtract per step.
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (state_reg)
            ST_STEP1: begin
                add_a   = ACC_W'(x_reg);
                add_b   = ACC_W'(s2);
                add_sub = 1'b1;
            end
            ST_STEP2: begin
                add_a   = acc_reg;
                add_b   = p24;
                add_sub = 1'b1;
            end
            ST_STEP3: begin
                add_a   = acc_reg;
                add_b   = pg;
                add_sub = 1'b1;
            end
            ST_STEP5: begin
                add_b = p24;
            end
            ST_STEP7: begin
                add_a = ACC_W'(s1);
                add_b = pg;
            end
            ST_STEP8: begin
                add_a = ACC_W'(yb_reg);
                add_b = pg;
            end
            ST_STEP9: begin
                add_a = ACC_W'(s2);
                add_b = pg;
            end
            ST_STEP10: begin
                add_a = ACC_W'(yl_reg);
                add_b = pg;
            end
            ST_STEP11: begin
                add_a   = ACC_W'(yl_reg);
                add_b   = p24;
                add_sub = 1'b1;
            end
            ST_STEP12: begin
                add_a = acc_reg;
                add_b = ACC_W'(yh_reg);
            end
            default: begin
            end
        endcase
        sum = add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    assign sum_sat32 = sat32(sum);
    assign sum_sat24 = sat24(sum);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start && in_range) begin
                    if (cfg.bypass) begin
                        state_next = item.req_type ? ST_IDLE : ST_FINISH;
                    end else begin
                        state_next = ST_STEP1;
                    end
                end
            end
            ST_STEP1:  state_next = ST_STEP2;
            ST_STEP2:  state_next = ST_STEP3;
            ST_STEP3:  state_next = ST_STEP4;
            ST_STEP4:  state_next = ST_STEP5;
            ST_STEP5:  state_next = ST_STEP6;
            ST_STEP6:  state_next = ST_STEP7;
            ST_STEP7:  state_next = ST_STEP8;
            ST_STEP8:  state_next = ST_STEP9;
            ST_STEP9:  state_next = ST_STEP10;
            ST_STEP10: state_next = req_reg ? ST_IDLE : ST_STEP11;
            ST_STEP11: state_next = ST_STEP12;
            ST_STEP12: state_next = ST_FINISH;
            ST_FINISH: begin
                if (res_taken) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
            if (mul_en) begin
                prod_reg <= prod_next;
            end
            if (start) begin
                req_reg <= item.req_type;
                ch_reg  <= item.channel;
                x_reg   <= item.req_type ? '0 : item.sample_in;
                y_reg   <= item.sample_in;
            end
            case (state_reg)
                ST_STEP1, ST_STEP2, ST_STEP11: acc_reg <= sum;
                ST_STEP3:  t_reg   <= sum_sat32;
                ST_STEP5:  yh_reg  <= sum_sat32;
                ST_STEP7:  yb_reg  <= sum_sat32;
                ST_STEP8:  s1n_reg <= sum_sat32;
                ST_STEP9:  yl_reg  <= sum_sat32;
                ST_STEP12: y_reg   <= sum_sat24;
                default: begin
                end
            endcase
        end
    end

    assign idle        = (state_reg == ST_IDLE);
    assign res_valid   = (state_reg == ST_FINISH);
    assign res.channel = ch_reg;
    assign res.value   = y_reg;

    `ASSERT_IMPLIES(a_start_when_idle, aclk, aresetn, start, state_reg == ST_IDLE, "item started while busy")
    `ASSERT_IMPLIES(a_no_silent_result, aclk, aresetn, res_valid, !req_reg, "result raised for a silent request")

endmodule

`default_nettype wire

### hdl/multichannel_svf_allpass_top.sv
// ----------------------------------------------------------------------------
// multichannel_svf_allpass_top
// Filter request: result after all steps; a silent request ends without a result.
// Bypass: the sample passes straight through and its channel state is cleared.
// Items go one at a time; the six products of a step share a single multiplier and adder.
// Reset: all channel states read as zero, coef_g = 0, coef_h = 0, bypass = 1.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multichannel_svf_allpass_top #(
    parameter int NUM_CHANNELS = svfap_pkg::DEFAULT_NUM_CHANNELS
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Configuration write port.
    input  logic                                 cfg_wr_en,
    input  logic [svfap_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [svfap_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Input channel.
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_req_type,
    input  logic [svfap_pkg::CH_W-1:0]           s_channel,
    input  logic signed [svfap_pkg::SAMPLE_W-1:0] s_sample_in,
    // Result channel.
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [svfap_pkg::CH_W-1:0]           m_channel_out,
    output logic signed [svfap_pkg::SAMPLE_W-1:0] m_allpass_out
);
    import svfap_pkg::*;

    // Only channels the 3-bit channel field can address get memory entries.
    localparam int MEM_DEPTH = (NUM_CHANNELS < MAX_CHANNELS) ? NUM_CHANNELS : MAX_CHANNELS;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    logic [G_W-1:0] coef_g_reg;
    logic [H_W-1:0] coef_h_reg;
    logic           bypass_reg;

    logic                   m_valid_reg;
    logic [CH_W-1:0]        m_channel_out_reg;
    logic signed [SAMPLE_W-1:0] m_allpass_out_reg;

    item_t                  item;
    cfg_t                   cfg;
    mem_cmd_t               mem_cmd;
    logic [MEM_AW-1:0]      mem_addr;
    logic [2*STATE_W-1:0]   mem_wdata;
    logic [2*STATE_W-1:0]   mem_rdata;
    logic                   core_idle;
    logic                   core_res_valid;
    result_t                core_res;
    logic                   start;
    logic                   out_free;

    // Configuration registers. Software loads them while the block is idle;
    // a write to an index beyond the list is dropped.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_g_reg <= '0;
            coef_h_reg <= '0;
            bypass_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_COEF_G: coef_g_reg <= cfg_data[G_W-1:0];
                REG_COEF_H: coef_h_reg <= cfg_data[H_W-1:0];
                REG_BYPASS: bypass_reg <= cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign cfg.coef_g = coef_g_reg;
    assign cfg.coef_h = coef_h_reg;
    assign cfg.bypass = bypass_reg;

    // The core works on one item at a time. It takes an input transfer only
    // when its sequencer is idle, which also keeps the read of a channel's
    // state behind the write-back of the previous item on the same channel.
    assign item.req_type  = s_req_type;
    assign item.channel   = s_channel;
    assign item.sample_in = s_sample_in;
    assign s_ready        = core_idle;
    assign start          = s_valid && s_ready;

    svfap_mem #(
        .DEPTH (MEM_DEPTH),
        .AW    (MEM_AW)
    ) u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mem_cmd),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rdata   (mem_rdata)
    );

    svfap_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .AW           (MEM_AW)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start),
        .item      (item),
        .cfg       (cfg),
        .idle      (core_idle),
        .mem_cmd   (mem_cmd),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .mem_rdata (mem_rdata),
        .res_valid (core_res_valid),
        .res       (core_res),
        .res_taken (out_free)
    );

    // Output register. A finished result moves here as soon as the register
    // is empty or being emptied, so the core can take the next input transfer
    // while the consumer still holds off the previous result.
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (core_res_valid && out_free) begin
                m_valid_reg       <= 1'b1;
                m_channel_out_reg <= core_res.channel;
                m_allpass_out_reg <= core_res.value;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_channel_out = m_channel_out_reg;
    assign m_allpass_out = m_allpass_out_reg;

    `ASSERT_NEXT(a_result_loaded, aclk, aresetn, core_res_valid && out_free, m_valid_reg, "finished result not loaded")
    `ASSERT_IMPLIES(a_result_source, aclk, aresetn, $rose(m_valid_reg), $past(core_res_valid), "output valid without a core result")

endmodule

`default_nettype wire

### sim/multichannel_svf_allpass_top_tb.sv
// ----------------------------------------------------------------------------
// multichannel_svf_allpass_top_tb
// Self-checking bench for the multichannel state-variable allpass filter.
// A queue-fed driver offers filter and silent requests on the input channel.
// A bit-exact fixed-point predictor of the integrator recursion keeps one
// state pair per channel and computes the expected result of every accepted filter
// request. A monitor checks each result against the oldest expectation while
// coefficient phases, bypass and idling patterns change between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_svf_allpass_top_tb;

    import svfap_pkg::*;

    localparam int NUM_CH       = 8;
    localparam int DRAIN_CYCLES = 24;
    localparam int LIMIT_NS     = 10_000_000;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 75;

    // Request kinds carried by s_req_type.
    localparam logic REQ_FILTER = 1'b0;
    localparam logic REQ_SILENT = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] FULL_POS = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] FULL_NEG = 24'sh800000;

    localparam longint NODE_MAX = 64'sd2147483647;
    localparam longint NODE_MIN = -64'sd2147483648;
    localparam longint OUT_MAX  = 64'sd8388607;
    localparam longint OUT_MIN  = -64'sd8388608;

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index     = '0;
    logic [CFG_DATA_W-1:0]      cfg_data      = '0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic                       s_req_type    = 1'b0;
    logic [CH_W-1:0]            s_channel     = '0;
    logic signed [SAMPLE_W-1:0] s_sample_in   = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic [CH_W-1:0]            m_channel_out;
    logic signed [SAMPLE_W-1:0] m_allpass_out;

    // Requests waiting to be offered, and allpass results still owed by the block.
    item_t   audio_requests[$];
    result_t expected_allpass[$];
    item_t   offered_req;

    // Shadow copy of the coefficient registers and of the per-channel integrators.
    longint  gain_g      = 0;
    longint  gain_h      = 0;
    logic    bypass_on   = 1'b1;
    longint  band_st[NUM_CH];
    longint  low_st[NUM_CH];

    // Idling in percent per cycle for each side, changed between phases.
    int      send_idle_pct  = 0;
    int      recv_stall_pct = 0;
    int      mismatches     = 0;

    multichannel_svf_allpass_top #(
        .NUM_CHANNELS (NUM_CH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_channel     (s_channel),
        .s_sample_in   (s_sample_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_channel_out (m_channel_out),
        .m_allpass_out (m_allpass_out)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------

    // Every internal node of the filter lives in Q9.23 and saturates to 32 bits.
    function automatic longint sat_node(longint v);
        if (v > NODE_MAX) return NODE_MAX;
        if (v < NODE_MIN) return NODE_MIN;
        return v;
    endfunction

    // Round half up: add half an LSB, then an arithmetic shift floors the value.
    function automatic longint round_shr(longint v, int sh);
        return (v + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint times_g(longint v);
        return round_shr(v * gain_g, G_FRAC);
    endfunction

    function automatic longint times_q24(longint v, longint k);
        return round_shr(v * k, Q24_FRAC);
    endfunction

    // Advances the shadow integrators of one channel by one request and queues
    // the allpass output when the request is a filter request.
    function automatic void predict_allpass(item_t req);
        longint  x, s1, s2, t, yh, yb, yl, y;
        longint  sqrt2;
        int      ch;
        result_t res;
        ch    = int'(req.channel);
        x     = longint'(req.sample_in);
        sqrt2 = longint'(SQRT2_Q24);
        if (ch >= NUM_CH) return;
        if (bypass_on) begin
            // Bypass wipes the channel and hands the sample straight through.
            band_st[ch] = 0;
            low_st[ch]  = 0;
            y = x;
        end else begin
            // A silent request runs the recursion on a zero input.
            if (req.req_type == REQ_SILENT) x = 0;
            s1 = band_st[ch];
            s2 = low_st[ch];
            t  = sat_node(x - times_q24(s1, sqrt2) - times_g(s1) - s2);
            yh = sat_node(times_q24(t, gain_h));
            yb = sat_node(times_g(yh) + s1);
            band_st[ch] = sat_node(times_g(yh) + yb);
            yl = sat_node(times_g(yb) + s2);
            low_st[ch]  = sat_node(times_g(yb) + yl);
            y  = yl - times_q24(yb, sqrt2) + yh;
        end
        if (req.req_type == REQ_SILENT) return;
        if (y > OUT_MAX) y = OUT_MAX;
        if (y < OUT_MIN) y = OUT_MIN;
        res.channel = ch[CH_W-1:0];
        res.value   = y[SAMPLE_W-1:0];
        expected_allpass.push_back(res);
    endfunction

    task automatic flag_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------

    // The slot is free when nothing is offered or the offered request transfers
    // at this edge. A request that transfers is handed to the predictor here,
    // before its result can possibly come back. Valid is assigned once per edge,
    // so back-to-back requests keep it high without a glitch.
    always @(posedge aclk) begin : request_driver
        item_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) begin
                predict_allpass(offered_req);
            end
            if (audio_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req    = audio_requests.pop_front();
                offered_req = next_req;
                s_valid     <= 1'b1;
                s_req_type  <= next_req.req_type;
                s_channel   <= next_req.channel;
                s_sample_in <= next_req.sample_in;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------

    // Every result transfer is compared field by field with the oldest
    // expectation. The ready line is redrawn each cycle from the stall rate.
    always @(posedge aclk) begin : result_monitor
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_allpass.size() == 0) begin
                    flag_mismatch($sformatf("result with none pending: ch %0d value %0d",
                                            m_channel_out, m_allpass_out));
                end else begin
                    want = expected_allpass.pop_front();
                    if (m_channel_out !== want.channel)
                        flag_mismatch($sformatf("channel_out %0d, want %0d",
                                                m_channel_out, want.channel));
                    if (m_allpass_out !== want.value)
                        flag_mismatch($sformatf("allpass_out %0d, want %0d on ch %0d",
                                                m_allpass_out, want.value, want.channel));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic add_request(logic req, int ch, logic signed [SAMPLE_W-1:0] smp);
        item_t it;
        it.req_type  = req;
        it.channel   = ch[CH_W-1:0];
        it.sample_in = smp;
        audio_requests.push_back(it);
    endtask

    // Waits at falling edges, where all updates of the rising edge have settled,
    // until everything is sent and answered. Silent requests leave no trace in
    // the expectations, so a further pause covers any step still in progress.
    task automatic wait_drained();
        do @(negedge aclk);
        while (audio_requests.size() != 0 || s_valid || expected_allpass.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Writes all three registers on consecutive edges; the block is idle here.
    task automatic load_coefs(logic [G_W-1:0] g, logic [H_W-1:0] h, logic byp);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_COEF_G;
        cfg_data  <= CFG_DATA_W'(g);
        @(posedge aclk);
        cfg_index <= REG_COEF_H;
        cfg_data  <= h;
        @(posedge aclk);
        cfg_index <= REG_BYPASS;
        cfg_data  <= CFG_DATA_W'(byp);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        gain_g    = longint'(g);
        gain_h    = longint'(h);
        bypass_on = byp;
    endtask

    // Normalizing gain 1 / (1 + sqrt2*g + g*g) in Q1.24 for a Q8.16 tangent.
    function automatic logic [H_W-1:0] norm_gain(logic [G_W-1:0] g);
        real gr, hr;
        gr = $itor(g) / 65536.0;
        hr = 1.0 / (1.0 + 1.4142135623730951 * gr + gr * gr);
        return H_W'($rtoi(hr * 16777216.0 + 0.5));
    endfunction

    // Mostly filter requests with random content, in runs on one channel so
    // the integrators build up history, plus silent requests and full-scale
    // samples that push the nodes into saturation.
    task automatic add_random_requests(int count);
        int   ch;
        int   pick;
        logic req;
        logic signed [SAMPLE_W-1:0] smp;
        ch = $urandom_range(NUM_CH - 1);
        repeat (count) begin
            req = ($urandom_range(99) < 12) ? REQ_SILENT : REQ_FILTER;
            if ($urandom_range(1) == 0) ch = $urandom_range(NUM_CH - 1);
            pick = $urandom_range(99);
            if (pick < 10)
                smp = $urandom_range(1) ? FULL_POS : FULL_NEG;
            else if (pick < 40)
                smp = SAMPLE_W'(int'($urandom_range(8191)) - 4096);
            else
                smp = SAMPLE_W'($urandom);
            add_request(req, ch, smp);
        end
    endtask

    initial begin : stimulus
        logic [G_W-1:0] g;
        logic [H_W-1:0] h;
        logic           byp;
        for (int i = 0; i < NUM_CH; i++) begin
            band_st[i] = 0;
            low_st[i]  = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: out of reset the block is in bypass, so samples pass
        // through and a silent request only clears its channel.
        add_request(REQ_FILTER, 0, FULL_POS);
        add_request(REQ_FILTER, 7, FULL_NEG);
        add_request(REQ_SILENT, 3, 24'sh123456);
        add_request(REQ_FILTER, 5, 24'sd0);
        add_request(REQ_FILTER, 2, -24'sd1);
        wait_drained();

        // Directed: a quarter-band filter. An impulse rings out on one channel,
        // silent requests advance it with their sample ignored, and a run of
        // negative full scale drives the integrators toward saturation.
        g = 24'd27146;
        load_coefs(g, norm_gain(g), 1'b0);
        add_request(REQ_FILTER, 1, FULL_POS);
        repeat (4) add_request(REQ_FILTER, 1, 24'sd0);
        add_request(REQ_SILENT, 1, FULL_POS);
        add_request(REQ_SILENT, 1, FULL_NEG);
        add_request(REQ_FILTER, 1, 24'sd0);
        repeat (3) add_request(REQ_FILTER, 6, FULL_NEG);
        add_request(REQ_FILTER, 0, 24'sh555555);
        add_request(REQ_FILTER, 0, 24'shAAAAAA);
        add_request(REQ_FILTER, 7, 24'sd1);
        wait_drained();

        // Random phases, each with its own coefficients and idling pattern.
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            byp = 1'b0;
            case (phase)
                0: g = '0;                                  // no shift at all
                1: g = '1;                                  // largest tangent
                2: g = G_W'($urandom_range(60000, 100));
                3: g = G_W'($urandom);                      // paired with zero h
                4: begin
                    g   = G_W'($urandom_range(200000, 1000));
                    byp = 1'b1;
                end
                5: g = G_W'($urandom_range(30000, 200));    // paired with h above one
                6: g = G_W'($urandom);
                default: g = G_W'($urandom_range(400000, 30000));
            endcase
            case (phase)
                3:       h = '0;
                5:       h = '1;
                default: h = norm_gain(g);
            endcase
            load_coefs(g, h, byp);

            // Cycle through free running, a slow sender, a slow receiver,
            // and both sides idling part of the time.
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            add_random_requests(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial begin : watchdog
        #(LIMIT_NS);
        $display("simulation failed");
        $finish;
    end

endmodule
